// ----- src/psum_pkg.sv -----
`default_nettype none
package psum_pkg;

    // set size and value width
    localparam int MAX_ELEMENTS = 1024;
    localparam int VALUE_WIDTH  = 32;

    // fixed port widths
    localparam int VALUE_PORT_W = 32;
    localparam int TARGET_W     = 33;

    // count must hold MAX_ELEMENTS itself
    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

    typedef logic signed [VALUE_WIDTH-1:0] t_key;
    typedef logic [CNT_W-1:0]              t_count;

    // broadcast control for one chain of cells
    typedef struct packed {
        logic   ins;
        logic   shift;
        t_key   key;
        t_count count;
    } t_chain_ctrl;

    typedef enum logic [1:0] {
        ST_LOAD = 2'b01,
        ST_WALK = 2'b10
    } t_state;

endpackage
`default_nettype wire

// ----- src/psum_cell.sv -----
`default_nettype none
module psum_cell
    import psum_pkg::*;
(
    input  wire              i_clk,
    input  wire t_chain_ctrl i_ctrl,
    input  wire t_count      i_idx,
    input  wire t_key        i_prev_key,
    input  wire              i_prev_gt,
    input  wire t_key        i_next_key,
    output t_key             o_key,
    output logic             o_gt
);

    t_key r_key;
    t_key n_key;

    // empty slot counts as larger than any key
    assign o_gt  = (i_idx >= i_ctrl.count) || (r_key > i_ctrl.key);
    assign o_key = r_key;

    // insert: take the key or the left neighbour's entry; walk: take the right one
    always_comb begin
        n_key = r_key;
        if (i_ctrl.shift) begin
            n_key = i_next_key;
        end else if (i_ctrl.ins && o_gt) begin
            n_key = i_prev_gt ? i_prev_key : i_ctrl.key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule
`default_nettype wire

// ----- src/psum_chain.sv -----
`default_nettype none
module psum_chain
    import psum_pkg::*;
(
    input  wire              i_clk,
    input  wire t_chain_ctrl i_ctrl,
    output t_key             o_head
);

    t_key w_key [MAX_ELEMENTS];
    logic w_gt  [MAX_ELEMENTS];

    // row of sorting cells, smallest key at cell 0
    for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
        t_key w_prev_key;
        logic w_prev_gt;
        t_key w_next_key;

        if (i == 0) begin : g_first
            assign w_prev_key = i_ctrl.key;
            assign w_prev_gt  = 1'b0;
        end else begin : g_mid
            assign w_prev_key = w_key[i-1];
            assign w_prev_gt  = w_gt[i-1];
        end

        if (i == MAX_ELEMENTS - 1) begin : g_last
            assign w_next_key = w_key[i];
        end else begin : g_inner
            assign w_next_key = w_key[i+1];
        end

        psum_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (i_ctrl),
            .i_idx      (t_count'(i)),
            .i_prev_key (w_prev_key),
            .i_prev_gt  (w_prev_gt),
            .i_next_key (w_next_key),
            .o_key      (w_key[i]),
            .o_gt       (w_gt[i])
        );
    end

    assign o_head = w_key[0];

endmodule
`default_nettype wire

// ----- src/pair_sum_exists_two_pointer.sv -----
`default_nettype none
// Pair-sum detector. Values are loaded one beat per cycle while busy is low
// (a beat is taken when start is high and busy is low); each is inserted in
// the same cycle into two rows of sorting cells, one ascending and one
// holding the inverted values so that its head is the largest value. The
// beat with i_last set raises busy and starts the two-pointer walk, which
// looks at both row heads and drops one element per cycle until the heads
// sum to the target or fewer than two stored values remain; then the
// result beat appears on o_valid for exactly one cycle and busy falls in the
// same cycle. The receiver cannot stall: o_found and o_overflowed must be
// taken while o_valid is high. Beats beyond MAX_ELEMENTS are dropped and
// reported through o_overflowed. i_cfg_wdata is written to the target sum
// whenever i_cfg_we is high; write it only while no set is in progress.
module pair_sum_exists_two_pointer
    import psum_pkg::*;
(
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_cfg_we,
    input  wire [TARGET_W-1:0]       i_cfg_wdata,
    input  wire                      start,
    output logic                     busy,
    input  wire [VALUE_PORT_W-1:0]   i_value,
    input  wire                      i_last,
    output logic                     o_valid,
    output logic                     o_found,
    output logic                     o_overflowed
);

    t_state                      r_state;
    t_count                      r_count;
    t_count                      r_rem;
    logic                        r_drop;
    logic                        r_ovf;
    logic signed [TARGET_W-1:0]  r_target;
    logic                        r_valid;
    logic                        r_found;

    logic                        w_accept;
    logic                        w_room;
    logic                        w_ins;
    t_key                        w_val;
    t_key                        w_lo_head;
    t_key                        w_hi_inv;
    t_key                        w_hi_head;
    logic signed [TARGET_W-1:0]  w_sum;
    logic                        w_walk;
    logic                        w_more;
    logic                        w_eq;
    logic                        w_lt;
    t_chain_ctrl                 w_lo_ctrl;
    t_chain_ctrl                 w_hi_ctrl;

    assign busy     = (r_state == ST_WALK);
    assign w_accept = start && !busy;
    assign w_room   = (r_count < t_count'(MAX_ELEMENTS));
    assign w_ins    = w_accept && w_room;
    assign w_val    = i_value[VALUE_WIDTH-1:0];

    // pair sum of the two row heads, sign extended, never overflows
    assign w_hi_head = ~w_hi_inv;
    assign w_sum = {{(TARGET_W-VALUE_WIDTH){w_lo_head[VALUE_WIDTH-1]}}, w_lo_head}
                 + {{(TARGET_W-VALUE_WIDTH){w_hi_head[VALUE_WIDTH-1]}}, w_hi_head};
    assign w_walk = (r_state == ST_WALK);
    assign w_more = (r_rem >= t_count'(2));
    assign w_eq   = (w_sum == r_target);
    assign w_lt   = (w_sum < r_target);

    // chain control: ascending row and inverted row
    always_comb begin
        w_lo_ctrl.ins   = w_ins;
        w_lo_ctrl.shift = w_walk && w_more && !w_eq && w_lt;
        w_lo_ctrl.key   = w_val;
        w_lo_ctrl.count = r_count;
        w_hi_ctrl.ins   = w_ins;
        w_hi_ctrl.shift = w_walk && w_more && !w_eq && !w_lt;
        w_hi_ctrl.key   = ~w_val;
        w_hi_ctrl.count = r_count;
    end

    psum_chain u_lo_chain (
        .i_clk  (i_clk),
        .i_ctrl (w_lo_ctrl),
        .o_head (w_lo_head)
    );

    psum_chain u_hi_chain (
        .i_clk  (i_clk),
        .i_ctrl (w_hi_ctrl),
        .o_head (w_hi_inv)
    );

    // target register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
        end else if (i_cfg_we) begin
            r_target <= i_cfg_wdata;
        end
    end

    // load and walk control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
            r_rem   <= '0;
            r_drop  <= 1'b0;
            r_ovf   <= 1'b0;
            r_valid <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                ST_LOAD: begin
                    if (w_accept) begin
                        if (i_last) begin
                            r_rem   <= w_room ? r_count + t_count'(1) : r_count;
                            r_ovf   <= r_drop || !w_room;
                            r_count <= '0;
                            r_drop  <= 1'b0;
                            r_state <= ST_WALK;
                        end else if (w_room) begin
                            r_count <= r_count + t_count'(1);
                        end else begin
                            r_drop <= 1'b1;
                        end
                    end
                end
                ST_WALK: begin
                    priority if (!w_more) begin
                        r_valid <= 1'b1;
                        r_found <= 1'b0;
                        r_state <= ST_LOAD;
                    end else if (w_eq) begin
                        r_valid <= 1'b1;
                        r_found <= 1'b1;
                        r_state <= ST_LOAD;
                    end else begin
                        r_rem <= r_rem - t_count'(1);
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
        end
    end

    assign o_valid      = r_valid;
    assign o_found      = r_found;
    assign o_overflowed = r_ovf;

endmodule
`default_nettype wire
